/* rtl/core/gfmac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfmac_pkg
// Shared widths, register indexes and the pipeline lane type of the GF(2^16)
// region multiply-accumulate block.
// ----------------------------------------------------------------------------
package gfmac_pkg;

	localparam int GF_W        = 16;               // field word width
	localparam int STEPS       = 4;                // multiplier bits per stage
	localparam int STAGES      = GF_W / STEPS;     // register stages
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = GF_W;
	localparam int S_TDATA_W   = 2 * GF_W;         // src_word, dst_old
	localparam int M_TDATA_W   = GF_W;             // result_word

	localparam logic [GF_W-1:0] POLY_RESET = 16'h100B;
	localparam logic [GF_W-1:0] MULT_RESET = 16'h0001;

	typedef logic [GF_W-1:0] gf_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY  = 2'd0,
		REG_MULT  = 2'd1,
		REG_ACCUM = 2'd2
	} cfg_reg_t;

	// One word in flight: shifted source, running sum, end-of-region mark.
	typedef struct packed {
		gf_word_t v;
		gf_word_t acc;
		logic     last;
	} lane_t;

endpackage

/* rtl/core/gf16_region_multiply_accumulate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf16_region_multiply_accumulate
// Multiplies each streamed source word by a configured GF(2^16) constant and
// optionally xors the product into the old destination word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: src_word, dst_old; tlast
//  m_axis   | out | m_axis_tvalid/tready   | tdata: result_word; tlast
//  cfg      | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
//  One request per cycle sustained while m_axis keeps accepting results; the
//  four register stages each resolve four multiplier bits.
//  Reset empties all stages; the registers return to poly 0x100B,
//  multiplier 1, accumulate off.
//  A stall at m_axis holds the last stage; earlier stages keep filling the
//  gaps, and s_axis_tready drops only when all four stages are occupied.
//
module gf16_region_multiply_accumulate (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [gfmac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfmac_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [gfmac_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [15:0] src_word, [31:16] dst_old
	input  logic                               s_axis_tlast,  // last_in
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [gfmac_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [15:0] result_word
	output logic                               m_axis_tlast   // last_out
);
	import gfmac_pkg::*;

	// Configuration registers
	gf_word_t poly_q;
	gf_word_t mult_q;
	logic     accum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q  <= POLY_RESET;
			mult_q  <= MULT_RESET;
			accum_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLY:  poly_q  <= cfg_data[GF_W-1:0];
				REG_MULT:  mult_q  <= cfg_data[GF_W-1:0];
				REG_ACCUM: accum_q <= cfg_data[0];
				default:   ;  // unused index, write dropped
			endcase
		end
	end

	// Entry lane: the running sum starts at dst_old when accumulating, so the
	// final xor comes for free out of the multiply chain.
	lane_t lane_in;
	assign lane_in.v    = s_axis_tdata[GF_W-1:0];
	assign lane_in.acc  = accum_q ? s_axis_tdata[2*GF_W-1:GF_W] : '0;
	assign lane_in.last = s_axis_tlast;

	lane_t lane_s1, lane_s2, lane_s3, lane_s4;
	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	lane_t nxt1, nxt2, nxt3, nxt4;
	logic  rdy1, rdy2, rdy3, rdy4;

	// Each slice handles one nibble of the multiplier, low bits first.
	gfmac_mul_slice u_slice1 (
		.lane_in (lane_in),
		.coef    (mult_q[1*STEPS-1:0*STEPS]),
		.poly    (poly_q),
		.lane_out(nxt1)
	);
	gfmac_mul_slice u_slice2 (
		.lane_in (lane_s1),
		.coef    (mult_q[2*STEPS-1:1*STEPS]),
		.poly    (poly_q),
		.lane_out(nxt2)
	);
	gfmac_mul_slice u_slice3 (
		.lane_in (lane_s2),
		.coef    (mult_q[3*STEPS-1:2*STEPS]),
		.poly    (poly_q),
		.lane_out(nxt3)
	);
	gfmac_mul_slice u_slice4 (
		.lane_in (lane_s3),
		.coef    (mult_q[4*STEPS-1:3*STEPS]),
		.poly    (poly_q),
		.lane_out(nxt4)
	);

	// A stage moves when it is empty or the one after it moves.
	assign rdy4 = !vld_s4 || m_axis_tready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	// Payload: no reset needed.
	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) lane_s1 <= nxt1;
		if (rdy2 && vld_s1)        lane_s2 <= nxt2;
		if (rdy3 && vld_s2)        lane_s3 <= nxt3;
		if (rdy4 && vld_s3)        lane_s4 <= nxt4;
	end

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = lane_s4.acc;
	assign m_axis_tlast  = lane_s4.last;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// Back-pressure reaches the input only when every stage holds a word.
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4))
		else $error("input stalled with an empty stage");

	// An accepted request always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s1)
		else $error("accepted request lost at stage 1");

	// A blocked middle stage keeps its word.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !rdy3) |=> (vld_s2 && $stable(lane_s2)))
		else $error("stage 2 changed while blocked");

endmodule

/* rtl/core/gfmac_mul_slice.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfmac_mul_slice
// Four shift-and-xor steps of the carry-free multiply with polynomial
// reduction; one slice sits in front of each pipeline register.
// ----------------------------------------------------------------------------
module gfmac_mul_slice (
	input  gfmac_pkg::lane_t                    lane_in,
	input  logic [gfmac_pkg::STEPS-1:0]         coef,
	input  logic [gfmac_pkg::GF_W-1:0]          poly,
	output gfmac_pkg::lane_t                    lane_out
);
	import gfmac_pkg::*;

	always_comb begin
		gf_word_t v;
		gf_word_t acc;
		v   = lane_in.v;
		acc = lane_in.acc;
		for (int i = 0; i < STEPS; i++) begin
			if (coef[i]) begin
				acc = acc ^ v;
			end
			// multiply by x, fold x^16 back in
			if (v[GF_W-1]) begin
				v = {v[GF_W-2:0], 1'b0} ^ poly;
			end else begin
				v = {v[GF_W-2:0], 1'b0};
			end
		end
		lane_out.v    = v;
		lane_out.acc  = acc;
		lane_out.last = lane_in.last;
	end

endmodule

/* bench/gf16_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf16_result_checker
// Tracks the register writes and every accepted request, computes the GF(2^16)
// product (optionally xored into the old destination word), and checks each
// result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gf16_result_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gfmac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfmac_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               s_valid,
	input  logic                               s_ready,
	input  logic [gfmac_pkg::S_TDATA_W-1:0]    s_data,   // [15:0] src_word, [31:16] dst_old
	input  logic                               s_last,   // last_in
	input  logic                               m_valid,
	input  logic                               m_ready,
	input  logic [gfmac_pkg::M_TDATA_W-1:0]    m_data,   // [15:0] result_word
	input  logic                               m_last,   // last_out
	output int                                 mismatches,
	output int                                 in_flight
);
	import gfmac_pkg::*;

	typedef struct packed {
		gf_word_t word;
		logic     last;
	} region_word_t;

	gf_word_t     poly_q;
	gf_word_t     mult_q;
	logic         accum_q;
	region_word_t expected_words[$];
	int           errs = 0;

	// shift-and-add product, reducing by x^16 + poly on every overflow
	function automatic gf_word_t gf_scale(gf_word_t a, gf_word_t k, gf_word_t poly);
		gf_word_t sum;
		gf_word_t shifted;
		sum     = '0;
		shifted = a;
		for (int b = 0; b < GF_W; b++) begin
			if (k[b])
				sum ^= shifted;
			if (shifted[GF_W-1])
				shifted = {shifted[GF_W-2:0], 1'b0} ^ poly;
			else
				shifted = {shifted[GF_W-2:0], 1'b0};
		end
		return sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		region_word_t head;
		gf_word_t     prod;
		if (!arst_n) begin
			poly_q  = POLY_RESET;
			mult_q  = MULT_RESET;
			accum_q = 1'b0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_POLY:  poly_q  = cfg_data[GF_W-1:0];
					REG_MULT:  mult_q  = cfg_data[GF_W-1:0];
					REG_ACCUM: accum_q = cfg_data[0];
					default: ;
				endcase
			end
			if (m_valid && m_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result: result_word=%h last_out=%b",
						m_data[GF_W-1:0], m_last);
					errs++;
				end else begin
					head = expected_words.pop_front();
					if (m_data[GF_W-1:0] !== head.word) begin
						$error("result_word: expected %h, got %h",
							head.word, m_data[GF_W-1:0]);
						errs++;
					end
					if (m_last !== head.last) begin
						$error("last_out: expected %b, got %b", head.last, m_last);
						errs++;
					end
				end
			end
			if (s_valid && s_ready) begin
				prod = gf_scale(s_data[GF_W-1:0], mult_q, poly_q);
				if (accum_q)
					prod ^= s_data[2*GF_W-1:GF_W];
				expected_words.push_back('{word: prod, last: s_last});
			end
		end
		mismatches <= errs;
		in_flight  <= expected_words.size();
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives region words through the GF(2^16) multiply-accumulate block under
// several field polynomials, multipliers and accumulate settings, with random
// gaps on both streams and one long result stall; a checker predicts results.
// ----------------------------------------------------------------------------
module testbench;
	import gfmac_pkg::*;

	localparam int LATENCY        = 4;     // pipeline depth from the block header
	localparam int HOLD_CYCLES    = 64;    // long result stall, well past 4 stages
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving
	localparam int PHASES         = 14;
	localparam int PHASE_WORDS    = 75;    // 14 x 75 random requests

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_POLY;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_valid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_data = '0;   // [15:0] src_word, [31:16] dst_old
	logic                  s_last = 1'b0; // last_in
	logic                  m_axis_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;  // [15:0] result_word
	logic                  m_axis_tlast;  // last_out
	int                    mismatches;
	int                    in_flight;
	bit                    hold_off_req = 1'b0;

	gf16_region_multiply_accumulate uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	gf16_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_valid    (s_valid),
		.s_ready    (s_axis_tready),
		.s_data     (s_data),
		.s_last     (s_last),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_tready),
		.m_data     (m_axis_tdata),
		.m_last     (m_axis_tlast),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- sender
	int  sent_words = 0;
	bit  send_calm  = 1'b0;

	// Offers one request after a random gap and returns on the edge that takes it.
	// Valid stays high across back-to-back requests; it only drops for a gap.
	task automatic send_word(gf_word_t src, gf_word_t dst, logic last);
		int gap;
		if (sent_words % 40 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
		gap = send_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= {dst, src};
		s_last  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent_words++;
	endtask

	// Drop valid, let every outstanding result drain, then allow the pipe to empty.
	task automatic settle();
		s_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// All three registers in back-to-back writes; enable drops once at the end.
	task automatic configure(gf_word_t poly, gf_word_t mult, logic [CFG_DATA_W-1:0] acc_data);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POLY;
		cfg_data  <= poly;
		@(posedge clk);
		cfg_index <= REG_MULT;
		cfg_data  <= mult;
		@(posedge clk);
		cfg_index <= REG_ACCUM;
		cfg_data  <= acc_data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly random words, with the corner values now and then.
	function automatic gf_word_t pick_word();
		case ($urandom_range(0, 11))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h0001;
			default: return gf_word_t'($urandom());
		endcase
	endfunction

	// accumulate bit plus random upper bits, which the block must ignore
	function automatic logic [CFG_DATA_W-1:0] accum_data(logic on);
		logic [CFG_DATA_W-1:0] d;
		d    = CFG_DATA_W'($urandom());
		d[0] = on;
		return d;
	endfunction

	initial begin : stimulus
		gf_word_t poly;
		gf_word_t mult;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: poly 0x100B, multiplier one, overwrite -> result is src.
		send_word(16'h0000, 16'hFFFF, 1'b0);
		send_word(16'hFFFF, 16'h0000, 1'b0);
		send_word(16'h8000, 16'h1234, 1'b0);
		send_word(16'h0001, 16'hFFFF, 1'b1);
		settle();

		// Zero multiplier while accumulating: result is the old destination.
		configure(POLY_RESET, 16'h0000, accum_data(1'b1));
		send_word(16'hFFFF, 16'hA5A5, 1'b0);
		send_word(16'h0000, 16'hFFFF, 1'b0);
		send_word(16'h1357, 16'h0000, 1'b1);
		settle();

		// Zero source with a full multiplier, overwrite mode.
		configure(POLY_RESET, 16'hFFFF, accum_data(1'b0));
		send_word(16'h0000, 16'hFFFF, 1'b0);
		send_word(16'hFFFF, 16'hFFFF, 1'b0);
		send_word(16'h8000, 16'h0000, 1'b1);
		settle();

		// Every register at its top value; high source bits wrap through the reduction.
		configure(16'hFFFF, 16'hFFFF, accum_data(1'b1));
		send_word(16'hFFFF, 16'hFFFF, 1'b0);
		send_word(16'h8000, 16'h5A5A, 1'b0);
		send_word(16'h0001, 16'h0000, 1'b1);
		settle();

		// Polynomial zero does not define a field; the overflow just falls off.
		configure(16'h0000, 16'h8000, accum_data(1'b0));
		send_word(16'h8000, 16'h0000, 1'b0);
		send_word(16'hFFFF, 16'hFFFF, 1'b0);
		send_word(16'h0003, 16'h1111, 1'b1);
		settle();

		// Multiplier one in accumulate mode: src xor dst.
		configure(16'h002D, 16'h0001, accum_data(1'b1));
		send_word(16'hFFFF, 16'hF0F0, 1'b0);
		send_word(16'h1234, 16'h4321, 1'b1);
		settle();

		// Random regions under a fresh setting per phase.
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 4))
				0:       poly = POLY_RESET;
				1:       poly = 16'h002D;
				2:       poly = 16'hFFFF;
				3:       poly = 16'h0000;
				default: poly = gf_word_t'($urandom());
			endcase
			case ($urandom_range(0, 5))
				0:       mult = 16'h0000;
				1:       mult = 16'h0001;
				2:       mult = 16'hFFFF;
				default: mult = gf_word_t'($urandom());
			endcase
			configure(poly, mult, accum_data(1'($urandom_range(0, 1))));
			// one long result stall while the sender keeps offering
			if (p == 2)
				hold_off_req = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++)
				send_word(pick_word(), gf_word_t'($urandom()), $urandom_range(0, 7) == 0);
			settle();
		end

		if (in_flight != 0)
			$error("%0d results never arrived", in_flight);
		if (mismatches == 0 && in_flight == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// -------------------------------------------------------------- receiver
	initial begin : result_sink
		int  stall;
		int  taken;
		bit  calm;
		taken = 0;
		calm  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			stall = calm ? 0 : $urandom_range(0, 10);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
		end
	end

	// -------------------------------------------------------------- watchdog
	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_tready))
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
